[rtl/pcm_pkg.sv]
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared constants, types and arithmetic helpers for the piecewise colormap.
// ----------------------------------------------------------------------------
package pcm_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 63;
  localparam int COMP_W      = 10;   // output component width
  localparam int CODE_W      = 11;   // internal color code (linear red reaches 2047)
  localparam int TF          = 20;   // fraction bits of t and u
  localparam int HUE_W       = 31;   // blended hue, 11 code bits + TF fraction
  localparam int TURN_BITS   = 30;   // one hue turn
  localparam int PROD_W      = 51;   // s*v*fraction

  localparam logic [TF:0]          T_ONE     = (TF+1)'(1) << TF;
  localparam logic [COMP_W-1:0]    CODE_FULL = 10'd1023;

  // segment word layout
  localparam int MODE_BIT  = 62;
  localparam int COLOR_W   = 31;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RANGE_LOW  = 3'd0,
    CFG_RANGE_HIGH = 3'd1,
    CFG_PART_COUNT = 3'd2,
    CFG_SEGMENT_0  = 3'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    TC_ZERO,   // t = 0
    TC_FULL,   // t = 1
    TC_DIV     // t from the quotient
  } t_class_t;

  typedef struct packed {
    t_class_t         cls;
    logic [33:0]      rem;
    logic [32:0]      den;
    logic [TF-1:0]    quo;
  } div_stage_t;

  // floor(x / 1023), one estimate and one correction
  function automatic logic [11:0] div1023(input logic [21:0] x);
    logic [21:0] q;
    logic [21:0] back;
    logic [21:0] r;
    q    = (x + (x >> 10)) >> 10;
    back = (q << 10) - q;
    r    = x - back;
    if (r >= 22'd1023) q = q + 22'd1;
    return q[11:0];
  endfunction

  // a*(1-u) + b*u with TF fraction bits
  function automatic logic [32:0] blend_raw(input logic [CODE_W-1:0] a,
                                            input logic [CODE_W-1:0] b,
                                            input logic [TF:0] u);
    logic [32:0] wa;
    logic [32:0] wb;
    wa = 33'(a) * 33'(T_ONE - u);
    wb = 33'(b) * 33'(u);
    return wa + wb;
  endfunction

  function automatic logic [CODE_W-1:0] blend_code(input logic [CODE_W-1:0] a,
                                                   input logic [CODE_W-1:0] b,
                                                   input logic [TF:0] u);
    logic [32:0] raw;
    raw = blend_raw(a, b, u) + 33'(1 << (TF - 1));
    return raw[TF +: CODE_W];
  endfunction

endpackage

[rtl/pcm_sample_if.sv]
// ----------------------------------------------------------------------------
// pcm_sample_if
// Sample stream channel: valid/ready with one Q16.16 value per beat.
// ----------------------------------------------------------------------------
interface pcm_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcm_pkg::SAMPLE_W-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

[rtl/pcm_color_if.sv]
// ----------------------------------------------------------------------------
// pcm_color_if
// Color stream channel: valid/ready with one RGB triple per beat.
// ----------------------------------------------------------------------------
interface pcm_color_if;
  logic                        valid;
  logic                        ready;
  logic [pcm_pkg::COMP_W-1:0]  red;
  logic [pcm_pkg::COMP_W-1:0]  green;
  logic [pcm_pkg::COMP_W-1:0]  blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

[rtl/pcm_cfg_if.sv]
// ----------------------------------------------------------------------------
// pcm_cfg_if
// Register write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface pcm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pcm_pkg::CFG_INDEX_W-1:0]   index;
  logic [pcm_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/pcm_divider.sv]
// ----------------------------------------------------------------------------
// pcm_divider
// Pipelined restoring divider, one quotient bit per stage, TF stages.
// ----------------------------------------------------------------------------
module pcm_divider (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  pcm_pkg::div_stage_t     in_data,
  output logic                    out_valid,
  output logic [pcm_pkg::TF:0]    t
);
  import pcm_pkg::*;

  logic       stage_valid [0:TF];
  div_stage_t stage       [0:TF];

  assign stage_valid[0] = in_valid;
  assign stage[0]       = in_data;

  for (genvar k = 0; k < TF; k++) begin : g_step
    logic [33:0] shifted;
    logic        take;
    div_stage_t  nxt;

    always_comb begin
      shifted = {stage[k].rem[32:0], 1'b0};
      take    = shifted >= {1'b0, stage[k].den};
      nxt     = stage[k];
      nxt.rem = take ? shifted - {1'b0, stage[k].den} : shifted;
      nxt.quo = {stage[k].quo[TF-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[k+1] <= 1'b0;
      end else if (en) begin
        stage_valid[k+1] <= stage_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage[k+1] <= nxt;
      end
    end
  end

  assign out_valid = stage_valid[TF];

  always_comb begin
    case (stage[TF].cls)
      TC_FULL: t = T_ONE;
      TC_DIV:  t = {1'b0, stage[TF].quo};
      default: t = '0;
    endcase
  end

endmodule

[rtl/pcm_shade.sv]
// ----------------------------------------------------------------------------
// pcm_shade
// Segment pick, color blend, HSV to RGB and output scaling, six stages.
// ----------------------------------------------------------------------------
module pcm_shade #(
  parameter int MAX_SEGMENTS   = 4,
  parameter int COMPONENT_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [pcm_pkg::TF:0]                t,
  input  logic [2:0]                          part_count,
  input  logic [pcm_pkg::CFG_DATA_W-1:0]      seg_word [MAX_SEGMENTS],
  output logic                                out_valid,
  output logic [pcm_pkg::COMP_W-1:0]          red,
  output logic [pcm_pkg::COMP_W-1:0]          green,
  output logic [pcm_pkg::COMP_W-1:0]          blue
);
  import pcm_pkg::*;

  localparam int SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [COMP_W-1:0] FULL = COMP_W'((1 << COMPONENT_BITS) - 1);

  logic [5:0] vld;

  // ---- stage 1: segment and local fraction
  logic [2:0]             n;
  logic [2:0]             n_m1;
  logic [23:0]            tn;
  logic [2:0]             seg_raw;
  logic [2:0]             seg;
  logic [23:0]            u_wide;
  logic [CFG_DATA_W-1:0]  s1_word;
  logic [TF:0]            s1_u;
  logic                   s1_white;

  always_comb begin
    n       = (part_count > 3'(MAX_SEGMENTS)) ? 3'(MAX_SEGMENTS) : part_count;
    n_m1    = n - 3'd1;
    tn      = 24'(t) * 24'(n);
    seg_raw = tn[TF+2:TF];
    seg     = (seg_raw > n_m1) ? n_m1 : seg_raw;
    u_wide  = tn - {1'b0, seg, 20'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_word  <= seg_word[seg[SEG_W-1:0]];
      s1_u     <= u_wide[TF:0];
      s1_white <= (n == 3'd0);
    end
  end

  // ---- stage 2: blend
  logic [COLOR_W-1:0] c_lo;
  logic [COLOR_W-1:0] c_hi;
  logic [32:0]        hue_raw;
  logic               s2_hsv;
  logic [HUE_W-1:0]   s2_hue;
  logic [COMP_W-1:0]  s2_sat;
  logic [COMP_W-1:0]  s2_val;
  logic [CODE_W-1:0]  s2_code [3];

  assign c_lo    = s1_word[COLOR_W-1:0];
  assign c_hi    = s1_word[2*COLOR_W-1:COLOR_W];
  assign hue_raw = blend_raw(c_lo[10:0], c_hi[10:0], s1_u);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_hsv  <= s1_word[MODE_BIT] && !s1_white;
      s2_hue  <= hue_raw[HUE_W-1:0];
      s2_sat  <= COMP_W'(blend_code({1'b0, c_lo[20:11]}, {1'b0, c_hi[20:11]}, s1_u));
      s2_val  <= COMP_W'(blend_code({1'b0, c_lo[30:21]}, {1'b0, c_hi[30:21]}, s1_u));
      if (s1_white) begin
        s2_code[0] <= CODE_W'(CODE_FULL);
        s2_code[1] <= CODE_W'(CODE_FULL);
        s2_code[2] <= CODE_W'(CODE_FULL);
      end else begin
        s2_code[0] <= blend_code(c_lo[10:0], c_hi[10:0], s1_u);
        s2_code[1] <= blend_code({1'b0, c_lo[20:11]}, {1'b0, c_hi[20:11]}, s1_u);
        s2_code[2] <= blend_code({1'b0, c_lo[30:21]}, {1'b0, c_hi[30:21]}, s1_u);
      end
    end
  end

  // ---- stage 3: sector, fraction, s*v
  logic [32:0]           h6;
  logic                  s3_hsv;
  logic [2:0]            s3_sector;
  logic [TURN_BITS-1:0]  s3_frac;
  logic [19:0]           s3_p;
  logic [COMP_W-1:0]     s3_val;
  logic [CODE_W-1:0]     s3_code [3];

  assign h6 = 33'(s2_hue[TURN_BITS-1:0]) * 33'd6;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_hsv    <= s2_hsv;
      s3_sector <= h6[32:TURN_BITS];
      s3_frac   <= h6[TURN_BITS-1:0];
      s3_p      <= 20'(s2_sat) * 20'(s2_val);
      s3_val    <= s2_val;
      s3_code   <= s2_code;
    end
  end

  // ---- stage 4: chroma and s*v*fraction
  logic [TURN_BITS:0]  fe;
  logic [11:0]         chroma;
  logic                s4_hsv;
  logic [2:0]          s4_sector;
  logic [PROD_W-1:0]   s4_prod;
  logic [COMP_W-1:0]   s4_chroma;
  logic [COMP_W-1:0]   s4_val;
  logic [CODE_W-1:0]   s4_code [3];

  assign fe     = s3_sector[0] ? ((TURN_BITS+1)'(1) << TURN_BITS) - {1'b0, s3_frac}
                               : {1'b0, s3_frac};
  assign chroma = div1023(22'(s3_p) + 22'd511);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_hsv    <= s3_hsv;
      s4_sector <= s3_sector;
      s4_prod   <= PROD_W'(s3_p) * PROD_W'(fe);
      s4_chroma <= chroma[COMP_W-1:0];
      s4_val    <= s3_val;
      s4_code   <= s3_code;
    end
  end

  // ---- stage 5: secondary component and sector mux
  logic [PROD_W-1:0]  y;
  logic [11:0]        xq;
  logic [CODE_W-1:0]  xc;
  logic [CODE_W-1:0]  cc;
  logic [CODE_W-1:0]  mm;
  logic [CODE_W-1:0]  hsv_rgb [3];
  logic [CODE_W-1:0]  s5_code [3];

  always_comb begin
    y  = s4_prod + (PROD_W'(1023) << (TURN_BITS - 1));
    xq = div1023({1'b0, y[PROD_W-1:TURN_BITS]});
    cc = CODE_W'(s4_chroma);
    xc = (12'(xq) > 12'(cc)) ? cc : xq[CODE_W-1:0];
    mm = CODE_W'(s4_val) - cc;
    case (s4_sector)
      3'd0:    begin hsv_rgb[0] = cc; hsv_rgb[1] = xc; hsv_rgb[2] = '0; end
      3'd1:    begin hsv_rgb[0] = xc; hsv_rgb[1] = cc; hsv_rgb[2] = '0; end
      3'd2:    begin hsv_rgb[0] = '0; hsv_rgb[1] = cc; hsv_rgb[2] = xc; end
      3'd3:    begin hsv_rgb[0] = '0; hsv_rgb[1] = xc; hsv_rgb[2] = cc; end
      3'd4:    begin hsv_rgb[0] = xc; hsv_rgb[1] = '0; hsv_rgb[2] = cc; end
      default: begin hsv_rgb[0] = cc; hsv_rgb[1] = '0; hsv_rgb[2] = xc; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        s5_code[j] <= s4_hsv ? hsv_rgb[j] + mm : s4_code[j];
      end
    end
  end

  // ---- stage 6: saturate and scale to the output width
  logic [COMP_W-1:0] clamped [3];
  logic [11:0]       scaled  [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      clamped[j] = (s5_code[j] > CODE_W'(CODE_FULL)) ? CODE_FULL : s5_code[j][COMP_W-1:0];
      scaled[j]  = div1023(22'(20'(clamped[j]) * 20'(FULL)) + 22'd511);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red   <= scaled[0][COMP_W-1:0];
      green <= scaled[1][COMP_W-1:0];
      blue  <= scaled[2][COMP_W-1:0];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  assign out_valid = vld[5];

endmodule

[rtl/piecewise_colormap_hsv_rgb_core.sv]
// ----------------------------------------------------------------------------
// piecewise_colormap_hsv_rgb_core
// Maps a Q16.16 sample to an RGB color through up to four linear/HSV parts.
// ----------------------------------------------------------------------------
// One sample in, one color out, one beat per clock while the sink keeps up. A
// front register forms the normalized numerator and denominator, 20
// pipelined divider stages produce t one quotient bit each, and six shading
// stages pick the segment, blend, convert HSV to RGB and scale the result.
// The whole pipeline advances together; it holds only when the output
// register carries a beat the sink has not taken, so sample.ready drops in
// exactly that case. Registers are written through cfg (always ready) and
// must only change while no beat is in flight. Samples outside the range
// saturate, a zero span gives t = 0, and part_count of zero gives white.
// ----------------------------------------------------------------------------
module piecewise_colormap_hsv_rgb_core #(
  parameter int MAX_SEGMENTS   = 4,
  parameter int COMPONENT_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  pcm_sample_if.sink  sample,
  pcm_color_if.source color,
  pcm_cfg_if.sink     cfg
);
  import pcm_pkg::*;

  // configuration registers
  logic signed [31:0]     range_low;
  logic signed [31:0]     range_high;
  logic [2:0]             part_count;
  logic [CFG_DATA_W-1:0]  seg_word [MAX_SEGMENTS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= 32'sd0;
      range_high <= 32'sd65536;
      part_count <= 3'd0;
      for (int i = 0; i < MAX_SEGMENTS; i++) seg_word[i] <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_index_t'(cfg.index))
        CFG_RANGE_LOW:  range_low  <= cfg.data[31:0];
        CFG_RANGE_HIGH: range_high <= cfg.data[31:0];
        CFG_PART_COUNT: part_count <= cfg.data[2:0];
        default: ;
      endcase
      // segment registers follow the fixed ones; extra indexes are dropped
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        if (cfg.index == CFG_INDEX_W'(int'(CFG_SEGMENT_0) + i)) seg_word[i] <= cfg.data;
      end
    end
  end

  // global advance: stall only when the output beat is held
  logic en;
  logic out_valid;
  assign en           = !out_valid || color.ready;
  assign sample.ready = en;

  // front stage: numerator / denominator, direction fix, trivial cases
  logic signed [33:0] num_raw;
  logic signed [33:0] den_raw;
  logic signed [33:0] num;
  logic signed [33:0] den;
  div_stage_t         front;
  div_stage_t         front_reg;
  logic               front_valid;

  always_comb begin
    num_raw = 34'(sample.sample_value) - 34'(range_low);
    den_raw = 34'(range_high) - 34'(range_low);
    // reversed span runs the map backwards
    num = (den_raw < 0) ? -num_raw : num_raw;
    den = (den_raw < 0) ? -den_raw : den_raw;
    front     = '0;
    front.den = den[32:0];
    if (den == 0 || num <= 0) begin
      front.cls = TC_ZERO;
    end else if (num >= den) begin
      front.cls = TC_FULL;
    end else begin
      front.cls = TC_DIV;
      front.rem = num;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (en) begin
      front_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front_reg <= front;
    end
  end

  // t = num / den with TF fraction bits
  logic        t_valid;
  logic [TF:0] t;

  pcm_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_data   (front_reg),
    .out_valid (t_valid),
    .t         (t)
  );

  pcm_shade #(
    .MAX_SEGMENTS   (MAX_SEGMENTS),
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_shade (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (t_valid),
    .t          (t),
    .part_count (part_count),
    .seg_word   (seg_word),
    .out_valid  (out_valid),
    .red        (color.red),
    .green      (color.green),
    .blue       (color.blue)
  );

  assign color.valid = out_valid;

endmodule

[rtl/pcm_checker.sv]
// ----------------------------------------------------------------------------
// pcm_checker
// Port-level checks on the colormap core, bound to the top level.
// ----------------------------------------------------------------------------
module pcm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] red,
  input logic [9:0] green,
  input logic [9:0] blue
);

  // held color beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("color beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({red, green, blue}))
    else $error("color payload changed while stalled");

  // input backpressure only comes from a stalled output
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("sample not accepted without output stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("color valid after reset");

endmodule

bind piecewise_colormap_hsv_rgb_core pcm_checker u_pcm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (sample.ready),
  .out_valid (color.valid),
  .out_ready (color.ready),
  .red       (color.red),
  .green     (color.green),
  .blue      (color.blue)
);
